// ===== rtl/ata_pio_sector_transfer_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// assertion macros used by the sector transfer sequencer rtl
// ----------------------------------------------------------------------------
`ifndef ATA_PIO_SECTOR_TRANSFER_SEQUENCER_ASSERT_SVH
`define ATA_PIO_SECTOR_TRANSFER_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define APST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define APST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/apst_pkg.sv =====
// ----------------------------------------------------------------------------
// apst_pkg
// types and constants of the ata pio sector transfer sequencer
// ----------------------------------------------------------------------------
package apst_pkg;

  // input item kinds
  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_STATUS = 2'd1;
  localparam logic [1:0] REQ_DEVDAT = 2'd2;
  localparam logic [1:0] REQ_HOSTWR = 2'd3;

  // result kinds
  localparam logic [1:0] K_WRITE = 2'd0;
  localparam logic [1:0] K_READ  = 2'd1;
  localparam logic [1:0] K_DATA  = 2'd2;
  localparam logic [1:0] K_DONE  = 2'd3;

  // completion codes
  localparam logic [1:0] E_OK      = 2'd0;
  localparam logic [1:0] E_REJECT  = 2'd1;
  localparam logic [1:0] E_TIMEOUT = 2'd2;
  localparam logic [1:0] E_FAULT   = 2'd3;

  // configuration register indexes
  localparam logic CFG_POLL_LIMIT = 1'b0;
  localparam logic CFG_CAPACITY   = 1'b1;

  // status bits
  localparam int ST_BSY  = 15;
  localparam int ST_DRDY = 14;
  localparam int ST_DF   = 13;
  localparam int ST_DRQ  = 11;
  localparam int ST_ERR  = 8;

  // register offsets
  localparam logic [12:0] OFS_NONE     = 13'h0000;
  localparam logic [12:0] OFS_DATA     = 13'h1000;
  localparam logic [12:0] OFS_SECT_CNT = 13'h1004;
  localparam logic [12:0] OFS_CYL      = 13'h1008;
  localparam logic [12:0] OFS_CMD_DH   = 13'h100c;
  localparam logic [12:0] OFS_STATUS   = 13'h100e;

  // taskfile command and drive/head bytes
  localparam logic [7:0] CMD_RD  = 8'h20;
  localparam logic [7:0] CMD_WR  = 8'h30;
  localparam logic [7:0] DH_LBA  = 8'h40;
  localparam logic [7:0] DH_BASE = 8'ha0;

  localparam logic [19:0] POLL_LIMIT_RST = 20'h80000;

  localparam int MAX_RES = 4;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_READY    = 7'b0000010,
    PH_BSY_PRE  = 7'b0000100,
    PH_DRQ      = 7'b0001000,
    PH_DATA     = 7'b0010000,
    PH_BSY_POST = 7'b0100000,
    PH_CHECK    = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] start_block;
    logic [15:0] sector_count;
    logic        is_write;
    logic [15:0] status_word;
    logic [15:0] data_word;
  } item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [12:0] reg_offset;
    logic [15:0] reg_value;
    logic [1:0]  error_code;
    logic        last;
  } result_t;

  // results caused by one item, slot 0 first
  typedef struct packed {
    result_t [MAX_RES-1:0] res;
    logic [2:0]            cnt;
  } burst_t;

  function automatic result_t mk_res(logic [1:0] kind, logic [12:0] ofs,
                                     logic [15:0] val, logic [1:0] err);
    result_t r;
    r.out_kind   = kind;
    r.reg_offset = ofs;
    r.reg_value  = val;
    r.error_code = err;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/apst_seq.sv =====
// ----------------------------------------------------------------------------
// apst_seq
// sequencer state, configuration registers and the per-item step logic
// ----------------------------------------------------------------------------
module apst_seq
  import apst_pkg::*;
#(
  parameter int WORDS_PER_SECTOR = 256,
  parameter int MAX_SECTORS      = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        go,
  input  item_t       item,
  output burst_t      burst
);

  localparam int WL_W = $clog2(WORDS_PER_SECTOR + 1);

  logic [19:0]     poll_limit;
  logic [31:0]     disk_capacity;
  phase_t          phase, phase_next;
  logic [27:0]     lba_address, lba_address_next;
  logic [7:0]      sectors_left, sectors_left_next;
  logic [WL_W-1:0] words_left, words_left_next;
  logic [19:0]     poll_count, poll_count_next;
  logic            write_mode, write_mode_next;

  logic [19:0] poll_inc;
  logic        timeout;
  logic [32:0] range_end;
  logic        reject;
  logic [7:0]  sect_dec;
  logic [WL_W-1:0] words_dec;
  logic [7:0]  cmd;
  logic [2:0]  n;
  result_t [MAX_RES-1:0] res;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit    <= POLL_LIMIT_RST;
      disk_capacity <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POLL_LIMIT: poll_limit    <= cfg_wdata[19:0];
        CFG_CAPACITY:   disk_capacity <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // shared arithmetic
  assign poll_inc  = poll_count + 20'd1;
  assign timeout   = (poll_inc >= poll_limit);
  assign range_end = {1'b0, item.start_block} + 33'(item.sector_count);
  assign reject    = (item.sector_count > 16'(MAX_SECTORS)) ||
                     (range_end > {1'b0, disk_capacity});
  assign sect_dec  = sectors_left - 8'd1;
  assign words_dec = (words_left != '0) ? words_left - WL_W'(1) : words_left;
  assign cmd       = write_mode ? CMD_WR : CMD_RD;

  // step: next state and the results of one item
  always_comb begin
    phase_next        = phase;
    lba_address_next  = lba_address;
    sectors_left_next = sectors_left;
    words_left_next   = words_left;
    poll_count_next   = poll_count;
    write_mode_next   = write_mode;
    n                 = 3'd0;
    res               = '0;
    if (go) begin
      case (item.req_type)
        REQ_START: begin
          if (phase == PH_IDLE) begin
            if (reject) begin
              res[n[1:0]] = mk_res(K_DONE, OFS_NONE, 16'd0, E_REJECT);
              n = n + 3'd1;
            end else begin
              lba_address_next  = item.start_block[27:0];
              sectors_left_next = item.sector_count[7:0];
              write_mode_next   = item.is_write;
              words_left_next   = '0;
              phase_next        = PH_READY;
              poll_count_next   = '0;
              res[n[1:0]] = mk_res(K_READ, OFS_STATUS, 16'd0, E_OK);
              n = n + 3'd1;
            end
          end
        end
        REQ_STATUS: begin
          unique case (phase)
            PH_READY: begin
              if (item.status_word[ST_DRDY]) begin
                res[n[1:0]] = mk_res(K_WRITE, OFS_SECT_CNT,
                                     {lba_address[7:0], sectors_left}, E_OK);
                n = n + 3'd1;
                res[n[1:0]] = mk_res(K_WRITE, OFS_CYL, lba_address[23:8], E_OK);
                n = n + 3'd1;
                res[n[1:0]] = mk_res(K_WRITE, OFS_CMD_DH,
                                     {cmd, DH_BASE | DH_LBA | {4'd0, lba_address[27:24]}},
                                     E_OK);
                n = n + 3'd1;
                if (sectors_left == 8'd0) begin
                  res[n[1:0]] = mk_res(K_DONE, OFS_NONE, 16'd0, E_OK);
                  n = n + 3'd1;
                  phase_next = PH_IDLE;
                end else begin
                  phase_next      = PH_BSY_PRE;
                  poll_count_next = '0;
                  res[n[1:0]] = mk_res(K_READ, OFS_STATUS, 16'd0, E_OK);
                  n = n + 3'd1;
                end
              end else begin
                poll_count_next = poll_inc;
                if (timeout) begin
                  res[n[1:0]] = mk_res(K_DONE, OFS_NONE, 16'd0, E_TIMEOUT);
                  phase_next = PH_IDLE;
                end else begin
                  res[n[1:0]] = mk_res(K_READ, OFS_STATUS, 16'd0, E_OK);
                end
                n = n + 3'd1;
              end
            end
            PH_BSY_PRE, PH_BSY_POST: begin
              if (!item.status_word[ST_BSY]) begin
                if (phase == PH_BSY_PRE) begin
                  phase_next      = PH_DRQ;
                  poll_count_next = '0;
                end else begin
                  phase_next = PH_CHECK;
                end
                res[n[1:0]] = mk_res(K_READ, OFS_STATUS, 16'd0, E_OK);
              end else begin
                poll_count_next = poll_inc;
                if (timeout) begin
                  res[n[1:0]] = mk_res(K_DONE, OFS_NONE, 16'd0, E_TIMEOUT);
                  phase_next = PH_IDLE;
                end else begin
                  res[n[1:0]] = mk_res(K_READ, OFS_STATUS, 16'd0, E_OK);
                end
              end
              n = n + 3'd1;
            end
            PH_DRQ: begin
              if (item.status_word[ST_DRQ]) begin
                phase_next      = PH_DATA;
                words_left_next = WL_W'(WORDS_PER_SECTOR);
                if (!write_mode) begin
                  res[n[1:0]] = mk_res(K_READ, OFS_DATA, 16'd0, E_OK);
                  n = n + 3'd1;
                end
              end else begin
                poll_count_next = poll_inc;
                if (timeout) begin
                  res[n[1:0]] = mk_res(K_DONE, OFS_NONE, 16'd0, E_TIMEOUT);
                  phase_next = PH_IDLE;
                end else begin
                  res[n[1:0]] = mk_res(K_READ, OFS_STATUS, 16'd0, E_OK);
                end
                n = n + 3'd1;
              end
            end
            PH_CHECK: begin
              if (item.status_word[ST_DF] || item.status_word[ST_ERR]) begin
                res[n[1:0]] = mk_res(K_DONE, OFS_NONE, 16'd0, E_FAULT);
                phase_next = PH_IDLE;
              end else begin
                sectors_left_next = sect_dec;
                lba_address_next  = lba_address + 28'd1;
                if (sect_dec == 8'd0) begin
                  res[n[1:0]] = mk_res(K_DONE, OFS_NONE, 16'd0, E_OK);
                  phase_next = PH_IDLE;
                end else begin
                  phase_next      = PH_BSY_PRE;
                  poll_count_next = '0;
                  res[n[1:0]] = mk_res(K_READ, OFS_STATUS, 16'd0, E_OK);
                end
              end
              n = n + 3'd1;
            end
            default: ;
          endcase
        end
        default: begin
          // data beats: device word in read mode, host word in write mode
          if (phase == PH_DATA &&
              ((item.req_type == REQ_HOSTWR) == write_mode)) begin
            res[n[1:0]] = mk_res((item.req_type == REQ_DEVDAT) ? K_DATA : K_WRITE,
                                 OFS_DATA, item.data_word, E_OK);
            n = n + 3'd1;
            words_left_next = words_dec;
            if (words_dec == '0) begin
              phase_next      = PH_BSY_POST;
              poll_count_next = '0;
              res[n[1:0]] = mk_res(K_READ, OFS_STATUS, 16'd0, E_OK);
              n = n + 3'd1;
            end else if (item.req_type == REQ_DEVDAT) begin
              res[n[1:0]] = mk_res(K_READ, OFS_DATA, 16'd0, E_OK);
              n = n + 3'd1;
            end
          end
        end
      endcase
    end
    // mark the final result of the item
    for (int i = 0; i < MAX_RES; i++) begin
      res[i].last = (n == 3'(i + 1));
    end
  end

  assign burst.res = res;
  assign burst.cnt = n;

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      lba_address  <= '0;
      sectors_left <= '0;
      words_left   <= '0;
      poll_count   <= '0;
      write_mode   <= 1'b0;
    end else begin
      phase        <= phase_next;
      lba_address  <= lba_address_next;
      sectors_left <= sectors_left_next;
      words_left   <= words_left_next;
      poll_count   <= poll_count_next;
      write_mode   <= write_mode_next;
    end
  end

endmodule

// ===== rtl/ata_pio_sector_transfer_sequencer.sv =====
// ----------------------------------------------------------------------------
// ata_pio_sector_transfer_sequencer
// host-side lba28 pio read/write sectors sequencer with stream ports
// ----------------------------------------------------------------------------
// path: each item passes the input register, then its results the result buffer
// throughput: one input beat per cycle while each item causes at most one
//   result and m_tready stays high; an item with n results (n <= 4) sends
//   them one beat at a time, and the next item waits for the buffer to drain
// reset: synchronous, clears phase, counters, buffer occupancy and config to defaults
module ata_pio_sector_transfer_sequencer
  import apst_pkg::*;
#(
  parameter int WORDS_PER_SECTOR = 256,
  parameter int MAX_SECTORS      = 255
) (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // [31:0] start_block, [47:32] sector_count, [48] is_write,
  // [64:49] status_word, [80:65] data_word, [87:81] zero
  input  logic [87:0] s_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_tuser,
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [12:0] reg_offset, [28:13] reg_value, [30:29] error_code, [31] zero
  output logic [31:0] m_tdata,
  // [1:0] out_kind
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  logic      in_vld;
  item_t     in_item;
  logic      go;
  logic      buf_free;
  burst_t    burst;
  logic [2:0] burst_n;
  result_t [MAX_RES-1:0] buf_res;
  logic [2:0] left;
  logic [1:0] rd;
  result_t   cur;

  // input register
  assign s_tready = !in_vld || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_vld <= 1'b1;
    end else if (go) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.req_type     <= s_tuser;
      in_item.start_block  <= s_tdata[31:0];
      in_item.sector_count <= s_tdata[47:32];
      in_item.is_write     <= s_tdata[48];
      in_item.status_word  <= s_tdata[64:49];
      in_item.data_word    <= s_tdata[80:65];
    end
  end

  // process the held item once the result buffer empties
  assign buf_free = (left == 3'd0) || (left == 3'd1 && m_tready);
  assign go       = in_vld && buf_free;

  apst_seq #(
    .WORDS_PER_SECTOR (WORDS_PER_SECTOR),
    .MAX_SECTORS      (MAX_SECTORS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .go        (go),
    .item      (in_item),
    .burst     (burst)
  );

  assign burst_n = burst.cnt;

  // result buffer, drained one beat per cycle while m_tready is high
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= 3'd0;
      rd   <= 2'd0;
    end else if (go) begin
      left <= burst_n;
      rd   <= 2'd0;
    end else if (m_tvalid && m_tready) begin
      left <= left - 3'd1;
      rd   <= rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      buf_res <= burst.res;
    end
  end

  // output beat
  assign cur      = buf_res[rd];
  assign m_tvalid = (left != 3'd0);
  assign m_tdata  = {1'b0, cur.error_code, cur.reg_value, cur.reg_offset};
  assign m_tuser  = cur.out_kind;
  assign m_tlast  = cur.last;

`include "ata_pio_sector_transfer_sequencer_assert.svh"

  `APST_ASSERT_NOW(a_left_range, 1'b1, left <= 3'(MAX_RES), "result buffer overfilled")
  `APST_ASSERT_NEXT(a_load_count, go, left == $past(burst_n), "buffer count not loaded")
  `APST_ASSERT_NOW(a_last_tail, m_tvalid, m_tlast == (left == 3'd1), "tlast off the final beat")
  `APST_ASSERT_NEXT(a_item_held, in_vld && !go, in_vld, "held item dropped")

endmodule
